// ===== hw/rtl/nat_pkg.sv =====
// ----------------------------------------------------------------------------
// nat_pkg - shared types and codes for the NAT table
// Holds the request kinds, result status codes, sequencer states and the
// layout of one table entry as kept in memory.
// ----------------------------------------------------------------------------
`default_nettype none

package nat_pkg;

    // Request kinds; the fourth code is unused and completes at once
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [6:0]  COUNT_MAX          = 7'd127;
    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd30;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic        occupied;
        logic [15:0] key;
        logic [31:0] local_addr;
        logic [31:0] public_addr;
        logic [31:0] last_used;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nat_table_with_idle_aging.sv =====
// ----------------------------------------------------------------------------
// nat_table_with_idle_aging - NAT translation table with idle timeout
// Bounded id-keyed table of address pairs, aged by tick requests.
// ----------------------------------------------------------------------------
// Raise start with a request while busy is low; the request is taken at that
// edge. Lookup, insert and tick requests walk all entries through the single
// read port of the entry memory, one read per cycle; an insert that writes a
// new entry then passes through a write state, and the unused kind code skips
// the walk. Each request yields exactly one result, shown for one cycle with
// done high; the receiver cannot stall, so capture it then. After reset the
// block runs a clearing pass over all entries with busy high; idle_timeout
// may still be written then.
// Write idle_timeout only while the block is idle.
`default_nettype none

module nat_table_with_idle_aging import nat_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] id,
    input  wire logic [31:0] local_addr,
    input  wire logic [31:0] public_addr,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    output logic             done,
    output logic             hit,
    output logic [31:0]      found_local_addr,
    output logic [31:0]      found_public_addr,
    output logic [1:0]       status,
    output logic [6:0]       removed_count
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [15:0]   idle_timeout_reg, idle_timeout_next;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    // Hold the timeout register; a write lands at once
    assign idle_timeout_next = cfg_wr_en ? cfg_wr_data : idle_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= IDLE_TIMEOUT_RESET;
        end
        else
        begin
            idle_timeout_reg <= idle_timeout_next;
        end
    end

    // Sequencer: walk the table, modify entries in flight, write them back
    nat_seq #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .kind              (kind),
        .id                (id),
        .local_addr        (local_addr),
        .public_addr       (public_addr),
        .idle_timeout      (idle_timeout_reg),
        .done              (done),
        .hit               (hit),
        .found_local_addr  (found_local_addr),
        .found_public_addr (found_public_addr),
        .status            (status),
        .removed_count     (removed_count),
        .mem_we            (mem_we),
        .mem_waddr         (mem_waddr),
        .mem_wdata         (mem_wdata),
        .mem_re            (mem_re),
        .mem_raddr         (mem_raddr),
        .mem_rdata         (mem_rdata)
    );

    // Entry store: read of address n and write-back of address n-1 never
    // collide, so no forwarding is needed
    nat_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/nat_mem.sv =====
// ----------------------------------------------------------------------------
// nat_mem - entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_mem import nat_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nat_seq.sv =====
// ----------------------------------------------------------------------------
// nat_seq - scan sequencer
// Walks the entry store one address a cycle, modifies entries in flight and
// writes them back, then raises the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_seq import nat_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    kind,
    input  wire logic [15:0]   id,
    input  wire logic [31:0]   local_addr,
    input  wire logic [31:0]   public_addr,
    input  wire logic [15:0]   idle_timeout,
    output logic               done,
    output logic               hit,
    output logic [31:0]        found_local_addr,
    output logic [31:0]        found_public_addr,
    output logic [1:0]         status,
    output logic [6:0]         removed_count,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output entry_t             mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  wire entry_t        mem_rdata
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    state_t        state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [31:0]   tick_reg, tick_next;
    logic [1:0]    op_kind_reg, op_kind_next;
    logic [15:0]   op_id_reg, op_id_next;
    logic [31:0]   op_in_reg, op_in_next;
    logic [31:0]   op_ex_reg, op_ex_next;
    logic          dup_reg, dup_next;
    logic          free_found_reg, free_found_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic          done_reg, done_next;
    logic          hit_reg, hit_next;
    logic [31:0]   fin_reg, fin_next;
    logic [31:0]   fex_reg, fex_next;
    logic [1:0]    status_reg, status_next;
    logic [6:0]    removed_reg, removed_next;

    logic          last;
    logic          match;
    logic          expired;
    logic          dup_any;
    logic          free_any;
    logic [31:0]   idle_time;

    assign last      = (addr_reg == LAST_ADDR);
    assign match     = mem_rdata.occupied && (mem_rdata.key == op_id_reg);
    assign idle_time = tick_reg - mem_rdata.last_used;
    assign expired   = mem_rdata.occupied && (idle_time > {16'd0, idle_timeout});
    assign dup_any   = dup_reg || match;
    assign free_any  = free_found_reg || !mem_rdata.occupied;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && (kind != KIND_NONE))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last)
                begin
                    if ((op_kind_reg == KIND_INSERT) && !dup_any && free_any)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        addr_next       = addr_reg;
        tick_next       = tick_reg;
        op_kind_next    = op_kind_reg;
        op_id_next      = op_id_reg;
        op_in_next      = op_in_reg;
        op_ex_next      = op_ex_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        fin_next        = fin_reg;
        fex_next        = fex_reg;
        status_next     = status_reg;
        removed_next    = removed_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = addr_reg + AW'(1);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                addr_next = addr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_kind_next    = kind;
                    op_id_next      = id;
                    op_in_next      = local_addr;
                    op_ex_next      = public_addr;
                    dup_next        = 1'b0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    fin_next        = '0;
                    fex_next        = '0;
                    status_next     = ST_DONE;
                    removed_next    = '0;
                    addr_next       = '0;
                    if (kind == KIND_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                    if (kind == KIND_NONE)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                    end
                end
            end
            S_SCAN:
            begin
                mem_re    = !last;
                addr_next = addr_reg + AW'(1);
                case (op_kind_reg)
                    KIND_LOOKUP:
                    begin
                        if (match && !hit_reg)
                        begin
                            hit_next            = 1'b1;
                            fin_next            = mem_rdata.local_addr;
                            fex_next            = mem_rdata.public_addr;
                            mem_we              = 1'b1;
                            mem_wdata.last_used = tick_reg;
                        end
                    end
                    KIND_INSERT:
                    begin
                        if (match)
                        begin
                            dup_next = 1'b1;
                        end
                        if (!mem_rdata.occupied && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = addr_reg;
                        end
                    end
                    KIND_TICK:
                    begin
                        if (expired)
                        begin
                            mem_we             = 1'b1;
                            mem_wdata.occupied = 1'b0;
                            if (removed_reg != COUNT_MAX)
                            begin
                                removed_next = removed_reg + 7'd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (last)
                begin
                    if (op_kind_reg == KIND_INSERT)
                    begin
                        if (dup_any)
                        begin
                            status_next = ST_DUP;
                            done_next   = 1'b1;
                        end
                        else if (!free_any)
                        begin
                            status_next = ST_FULL;
                            done_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_WRITE:
            begin
                mem_we                = 1'b1;
                mem_waddr             = free_idx_reg;
                mem_wdata.occupied    = 1'b1;
                mem_wdata.key         = op_id_reg;
                mem_wdata.local_addr  = op_in_reg;
                mem_wdata.public_addr = op_ex_reg;
                mem_wdata.last_used   = tick_reg;
                done_next             = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            tick_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            tick_reg  <= tick_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_kind_reg    <= op_kind_next;
        op_id_reg      <= op_id_next;
        op_in_reg      <= op_in_next;
        op_ex_reg      <= op_ex_next;
        dup_reg        <= dup_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_reg        <= hit_next;
        fin_reg        <= fin_next;
        fex_reg        <= fex_next;
        status_reg     <= status_next;
        removed_reg    <= removed_next;
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign hit               = hit_reg;
    assign found_local_addr  = fin_reg;
    assign found_public_addr = fex_reg;
    assign status            = status_reg;
    assign removed_count     = removed_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/nat_checker.sv =====
// ----------------------------------------------------------------------------
// nat_checker - port-level checks for the NAT table
// Watches requests and results on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module nat_checker import nat_pkg::*; (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] kind,
    input wire logic       done,
    input wire logic       hit,
    input wire logic [1:0] status,
    input wire logic [6:0] removed_count
);

    // A table request keeps the block busy on the next cycle
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind != KIND_NONE)) |=> busy)
        else $error("busy low after a table request");

    // A result follows either a scan or an immediate request
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result strobe with no request behind it");

    // A hit comes only from a lookup
    a_hit_is_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> ((status == ST_DONE) && (removed_count == 7'd0)))
        else $error("hit together with insert status or removal count");

    // Removals come only from a tick
    a_removed_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (removed_count != 7'd0)) |-> (!hit && (status == ST_DONE)))
        else $error("removal count together with lookup or insert result");

endmodule

bind nat_table_with_idle_aging nat_checker u_nat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .done          (done),
    .hit           (hit),
    .status        (status),
    .removed_count (removed_count)
);

`default_nettype wire
